[rtl/framed_message_decoder_defines.svh]
// Assertion macros shared by the framed message decoder RTL.
`ifndef FRAMED_MESSAGE_DECODER_DEFINES_SVH
`define FRAMED_MESSAGE_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off during reset.
`define FMD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled on clk, off during reset.
`define FMD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FMD_ASSERT_IMP(lbl, ante, cons, msg)
`define FMD_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

[rtl/fmd_pkg.sv]
// Types, constants and byte layout decode for the framed message decoder.
package fmd_pkg;

  localparam int BYTE_W     = 8;
  localparam int FIELD_W    = 64;
  localparam int NUM_FIELDS = 6;
  localparam int IDX_W      = 3;
  localparam int LANE_W     = 3;
  localparam int POS_W      = 6;
  localparam int ID_W       = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int RECQ_DEPTH = 2;

  localparam logic [BYTE_W-1:0] SYNC_RESET        = 8'd170;
  localparam logic [ID_W-1:0]   POSITION_ID_RESET = 16'd36;
  localparam logic [ID_W-1:0]   SETUP_ID_RESET    = 16'd7;
  localparam logic [ID_W-1:0]   MEASURE_ID_RESET  = 16'd19;

  // header: three skipped bytes, then id low and id high
  localparam logic [POS_W-1:0] HEAD_ID_LO = 6'd3;
  localparam logic [POS_W-1:0] HEAD_ID_HI = 6'd4;

  typedef enum logic [1:0] {
    KIND_POSITION = 2'd0,
    KIND_SETUP    = 2'd1,
    KIND_MEASURE  = 2'd2
  } fmd_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SYNC        = 2'd0,
    CFG_POSITION_ID = 2'd1,
    CFG_SETUP_ID    = 2'd2,
    CFG_MEASURE_ID  = 2'd3
  } fmd_cfg_reg_t;

  typedef logic [NUM_FIELDS-1:0][FIELD_W-1:0] fmd_fields_t;

  typedef struct packed {
    fmd_kind_t   kind;
    fmd_fields_t vals;
  } fmd_rec_t;

  typedef struct packed {
    logic     push;
    fmd_rec_t rec;
  } fmd_push_t;

  typedef struct packed {
    logic     valid;
    fmd_rec_t rec;
  } fmd_head_t;

  // what one body byte does
  typedef struct packed {
    logic              acc;       // always summed
    logic              text;      // summed up to the first zero
    logic              chk_a;
    logic              chk_b;
    logic              wr;        // goes into a field lane
    logic              cfg_bits;  // packed bit fields of the setup record
    logic [IDX_W-1:0]  fsel;
    logic [LANE_W-1:0] lane;
    logic              last;
  } fmd_byte_op_t;

  function automatic fmd_byte_op_t fmd_decode(fmd_kind_t kind, logic [POS_W-1:0] pos);
    fmd_byte_op_t op;
    logic [POS_W-1:0] rel;
    op  = '0;
    rel = '0;
    unique case (kind)
      KIND_POSITION: begin
        op.acc   = (pos < 6'd36);
        op.chk_a = (pos == 6'd36);
        op.chk_b = (pos == 6'd37);
        op.last  = (pos == 6'd39);
        if (pos < 6'd24) begin
          // three f64 values
          op.wr   = 1'b1;
          op.fsel = pos[5:3];
          op.lane = pos[2:0];
        end else if (pos < 6'd36) begin
          // three f32 values
          rel     = pos - 6'd24;
          op.wr   = 1'b1;
          op.fsel = 3'd3 + {1'b0, rel[3:2]};
          op.lane = {1'b0, rel[1:0]};
        end
      end
      KIND_SETUP: begin
        op.acc   = (pos < 6'd7);
        op.chk_a = (pos == 6'd7);
        op.chk_b = (pos == 6'd8);
        op.last  = (pos == 6'd9);
        if (pos < 6'd2) begin
          op.wr   = 1'b1;
          op.fsel = 3'd0;
          op.lane = pos[2:0];
        end else if (pos == 6'd2) begin
          op.cfg_bits = 1'b1;
        end else if (pos < 6'd7) begin
          rel     = pos - 6'd3;
          op.wr   = 1'b1;
          op.fsel = 3'd5;
          op.lane = rel[2:0];
        end
      end
      KIND_MEASURE: begin
        op.text  = (pos >= 6'd4) && (pos <= 6'd8);
        op.acc   = (pos < 6'd4) || ((pos >= 6'd9) && (pos < 6'd19));
        op.chk_a = (pos == 6'd19);
        op.chk_b = (pos == 6'd20);
        op.last  = (pos == 6'd23);
        if (pos < 6'd4) begin
          op.wr   = 1'b1;
          op.fsel = 3'd0;
          op.lane = pos[2:0];
        end else if (pos <= 6'd8) begin
          rel     = pos - 6'd4;
          op.wr   = 1'b1;
          op.fsel = 3'd1;
          op.lane = rel[2:0];
        end else if (pos <= 6'd10) begin
          rel     = pos - 6'd9;
          op.wr   = 1'b1;
          op.fsel = 3'd2;
          op.lane = rel[2:0];
        end else if (pos <= 6'd18) begin
          rel     = pos - 6'd11;
          op.wr   = 1'b1;
          op.fsel = 3'd3;
          op.lane = rel[2:0];
        end
      end
      default: begin
        op.last = 1'b1;
      end
    endcase
    return op;
  endfunction

  function automatic logic [IDX_W-1:0] fmd_field_count(fmd_kind_t kind);
    return (kind == KIND_MEASURE) ? 3'd4 : 3'd6;
  endfunction

endpackage

[rtl/fmd_recq.sv]
// Two-entry queue of decoded records between the parser and the field emitter.
`include "framed_message_decoder_defines.svh"

module fmd_recq
  import fmd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  fmd_push_t push_i,
  input  logic      pop_i,
  output logic      full_o,
  output fmd_head_t head_o
);

  localparam int PTR_W = $clog2(RECQ_DEPTH);
  localparam int CNT_W = $clog2(RECQ_DEPTH + 1);

  fmd_rec_t          mem_r [RECQ_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              do_push;
  logic              do_pop;

  assign full_o       = (cnt_r == CNT_W'(RECQ_DEPTH));
  assign head_o.valid = (cnt_r != '0);
  assign head_o.rec   = mem_r[rd_ptr_r];
  assign do_push      = push_i.push && !full_o;
  assign do_pop       = pop_i && head_o.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(RECQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(RECQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_i.rec;
    end
  end

  `FMD_ASSERT_IMP(a_no_push_when_full, push_i.push, !full_o, "record pushed into full queue")
  `FMD_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(RECQ_DEPTH), "record count overflow")

endmodule

[rtl/fmd_front.sv]
// Frame parser: sync hunt, header, checksum and field assembly.
module fmd_front
  import fmd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  logic [BYTE_W-1:0]     data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output fmd_push_t             push_o
);

  typedef enum logic [1:0] {
    ST_HUNT,
    ST_HEAD,
    ST_BODY
  } state_t;

  state_t             state_r, state_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  fmd_kind_t          kind_r, kind_nxt;
  logic [BYTE_W-1:0]  id_lo_r, id_lo_nxt;
  logic [BYTE_W-1:0]  sum_a_r, sum_a_nxt;
  logic [BYTE_W-1:0]  sum_b_r, sum_b_nxt;
  logic               text_done_r, text_done_nxt;
  logic [BYTE_W-1:0]  chk_a_r, chk_a_nxt;
  logic [BYTE_W-1:0]  chk_b_r, chk_b_nxt;
  fmd_fields_t        fld_r, fld_nxt;

  logic [BYTE_W-1:0]  sync_r;
  logic [ID_W-1:0]    pos_id_r;
  logic [ID_W-1:0]    setup_id_r;
  logic [ID_W-1:0]    meas_id_r;

  fmd_byte_op_t       op;
  logic [ID_W-1:0]    id_full;
  logic [BYTE_W-1:0]  sum_a_inc;
  logic [BYTE_W-1:0]  sum_b_inc;
  logic               text_live;
  logic               match;

  always_comb begin
    op        = fmd_decode(kind_r, pos_r);
    id_full   = {data, id_lo_r};
    sum_a_inc = sum_a_r + data;
    sum_b_inc = sum_b_r + sum_a_inc;
    text_live = op.text && !text_done_r;
    match     = (sum_a_r == chk_a_r) && (sum_b_r == chk_b_r);

    state_nxt     = state_r;
    pos_nxt       = pos_r;
    kind_nxt      = kind_r;
    id_lo_nxt     = id_lo_r;
    sum_a_nxt     = sum_a_r;
    sum_b_nxt     = sum_b_r;
    text_done_nxt = text_done_r;
    chk_a_nxt     = chk_a_r;
    chk_b_nxt     = chk_b_r;
    fld_nxt       = fld_r;

    push_o.push     = 1'b0;
    push_o.rec.kind = kind_r;
    push_o.rec.vals = fld_r;

    if (accept) begin
      unique case (state_r)
        ST_HUNT: begin
          if (data == sync_r) begin
            state_nxt = ST_HEAD;
            pos_nxt   = '0;
          end
        end
        ST_HEAD: begin
          if (pos_r == HEAD_ID_HI) begin
            state_nxt     = ST_BODY;
            pos_nxt       = '0;
            sum_a_nxt     = '0;
            sum_b_nxt     = '0;
            text_done_nxt = 1'b0;
            fld_nxt       = '0;
            // earlier ids win on collisions
            priority if (id_full == pos_id_r) begin
              kind_nxt = KIND_POSITION;
            end else if (id_full == setup_id_r) begin
              kind_nxt = KIND_SETUP;
            end else if (id_full == meas_id_r) begin
              kind_nxt = KIND_MEASURE;
            end else begin
              state_nxt = ST_HUNT;
            end
          end else begin
            if (pos_r == HEAD_ID_LO) begin
              id_lo_nxt = data;
            end
            pos_nxt = pos_r + 1'b1;
          end
        end
        ST_BODY: begin
          if (op.acc || text_live) begin
            sum_a_nxt = sum_a_inc;
            sum_b_nxt = sum_b_inc;
          end
          if (text_live && (data == '0)) begin
            text_done_nxt = 1'b1;
          end
          if (op.chk_a) begin
            chk_a_nxt = data;
          end
          if (op.chk_b) begin
            chk_b_nxt = data;
          end
          // text bytes from the first zero on stay zero
          if (op.wr && (!op.text || (text_live && (data != '0)))) begin
            for (int f = 0; f < NUM_FIELDS; f++) begin
              if (op.fsel == IDX_W'(f)) begin
                fld_nxt[f][{op.lane, 3'b000} +: BYTE_W] = data;
              end
            end
          end
          if (op.cfg_bits) begin
            fld_nxt[1] = FIELD_W'(data[1:0]);
            fld_nxt[2] = FIELD_W'(data[4:2]);
            fld_nxt[3] = FIELD_W'(data[5]);
            fld_nxt[4] = FIELD_W'(data[7:6]);
          end
          if (op.last) begin
            state_nxt   = ST_HUNT;
            pos_nxt     = '0;
            push_o.push = match;
          end else begin
            pos_nxt = pos_r + 1'b1;
          end
        end
        default: begin
          state_nxt = ST_HUNT;
          pos_nxt   = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_HUNT;
      pos_r       <= '0;
      kind_r      <= KIND_POSITION;
      text_done_r <= 1'b0;
      sync_r      <= SYNC_RESET;
      pos_id_r    <= POSITION_ID_RESET;
      setup_id_r  <= SETUP_ID_RESET;
      meas_id_r   <= MEASURE_ID_RESET;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      kind_r      <= kind_nxt;
      text_done_r <= text_done_nxt;
      if (cfg_we) begin
        unique case (fmd_cfg_reg_t'(cfg_index))
          CFG_SYNC:        sync_r     <= cfg_data[BYTE_W-1:0];
          CFG_POSITION_ID: pos_id_r   <= cfg_data;
          CFG_SETUP_ID:    setup_id_r <= cfg_data;
          CFG_MEASURE_ID:  meas_id_r  <= cfg_data;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    id_lo_r <= id_lo_nxt;
    sum_a_r <= sum_a_nxt;
    sum_b_r <= sum_b_nxt;
    chk_a_r <= chk_a_nxt;
    chk_b_r <= chk_b_nxt;
    fld_r   <= fld_nxt;
  end

endmodule

[rtl/fmd_back.sv]
// Field emitter: walks the head record one field per beat into the output register.
`include "framed_message_decoder_defines.svh"

module fmd_back
  import fmd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  fmd_head_t          head_i,
  input  logic               out_take,
  output logic               q_pop,
  output logic               out_valid,
  output logic [1:0]         out_kind,
  output logic [IDX_W-1:0]   out_index,
  output logic [FIELD_W-1:0] out_value,
  output logic               out_last
);

  logic [IDX_W-1:0]   idx_r;
  logic               ov_r;
  logic [1:0]         kind_r;
  logic [IDX_W-1:0]   index_r;
  logic [FIELD_W-1:0] value_r;
  logic               last_r;
  logic [IDX_W-1:0]   nfld;
  logic               load;
  logic               is_last;

  assign nfld    = fmd_field_count(head_i.rec.kind);
  assign load    = head_i.valid && (!ov_r || out_take);
  assign is_last = (idx_r == nfld - 1'b1);
  assign q_pop   = load && is_last;

  assign out_valid = ov_r;
  assign out_kind  = kind_r;
  assign out_index = index_r;
  assign out_value = value_r;
  assign out_last  = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      if (load) begin
        ov_r  <= 1'b1;
        idx_r <= is_last ? '0 : idx_r + 1'b1;
      end else if (out_take) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r  <= head_i.rec.kind;
      index_r <= idx_r;
      value_r <= head_i.rec.vals[idx_r];
      last_r  <= is_last;
    end
  end

  `FMD_ASSERT_IMP(a_idx_in_record, head_i.valid, idx_r < nfld, "field index past record end")
  `FMD_ASSERT_NXT(a_pop_rewinds, q_pop, idx_r == '0, "field index not rewound after record")
  `FMD_ASSERT_NXT(a_pop_marks_last, q_pop, ov_r && last_r, "record retired without last field")

endmodule

[rtl/framed_message_decoder.sv]
// Top level of the framed message decoder: parser, record queue and field emitter.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------------
//  in      | input     | push / full             | in_data_in (one stream byte)
//  out     | output    | empty / pop             | out_record_kind, out_field_index,
//          |           |                         | out_field_value, out_last_field
//  cfg     | input     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// One byte beat is taken every cycle while full is low; the parser works on each
// byte in the cycle it arrives.
// A good frame hands its record to a two-entry queue on its last byte; the emitter
// then sends one field per cycle while pop is held (6 fields, 4 for measurement); the
// record is queued first and its first field then loads into the output register.
// full rises only while both queue entries hold records, i.e. when the result side
// has stalled long enough to back up two whole records.
// cfg_ready is always high. Reset (rst_n low, synchronous) restores the control and config
// registers to their defaults and restarts the sync hunt; no clearing pass is needed.
module framed_message_decoder
  import fmd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // byte input
  input  logic                  push,
  output logic                  full,
  input  logic [BYTE_W-1:0]     in_data_in,
  // decoded fields
  output logic                  empty,
  input  logic                  pop,
  output logic [1:0]            out_record_kind,
  output logic [IDX_W-1:0]      out_field_index,
  output logic [FIELD_W-1:0]    out_field_value,
  output logic                  out_last_field,
  // register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  fmd_push_t front_push;
  fmd_head_t q_head;
  logic      q_full;
  logic      q_pop;
  logic      in_take;
  logic      out_take;
  logic      out_valid;

  // a byte beat lands when the queue has room for the record it might finish
  assign full      = q_full;
  assign in_take   = push && !q_full;
  assign empty     = !out_valid;
  assign out_take  = pop && out_valid;
  assign cfg_ready = 1'b1;

  fmd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_take),
    .data      (in_data_in),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push_o    (front_push)
  );

  fmd_recq u_recq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (front_push),
    .pop_i  (q_pop),
    .full_o (q_full),
    .head_o (q_head)
  );

  fmd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_i    (q_head),
    .out_take  (out_take),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_kind  (out_record_kind),
    .out_index (out_field_index),
    .out_value (out_field_value),
    .out_last  (out_last_field)
  );

endmodule
